FILE: sv/ssi_pkg.sv
package ssi_pkg;

  localparam int unsigned KEY_W     = 16;
  localparam int unsigned STEP_W    = 7;
  localparam int unsigned POINT_W   = 23;
  localparam int unsigned PCNT_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W    = 2 * KEY_W;
  localparam int unsigned DIV_STEPS = KEY_W;
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 32;
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = CFG_IDX_W'(0);

  typedef logic [POINT_W-1:0] point_t;

  typedef struct packed {
    logic             direct;
    logic             clamped;
    logic [KEY_W-1:0] base;
    logic             neg;
    logic [KEY_W-1:0] num;
    logic [KEY_W-1:0] mag;
    logic [KEY_W-1:0] den;
  } cls_t;

  typedef struct packed {
    logic [KEY_W-1:0] result;
    logic             clamped;
  } res_t;

endpackage

FILE: sv/speed_step_interpolator.sv
// An item passes the mid queue, the product register, the divider and the result queue.
// Throughput: one item per cycle unless stalled, kept by a 16-stage restoring divider.
// The back end issues only while its in-flight items fit in the 32-entry result queue.
// Reset clears the point count and all breakpoints to zero and empties both queues.
module speed_step_interpolator #(
  parameter int unsigned MAX_POINTS = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              op_i,
  input  logic [ssi_pkg::KEY_W-1:0]         value_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [ssi_pkg::KEY_W-1:0]         result_o,
  output logic                              clamped_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ssi_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ssi_pkg::POINT_W-1:0]       cfg_data_i
);

  import ssi_pkg::*;

  logic [PCNT_W-1:0]    count_q;
  point_t               points_q [MAX_POINTS];
  cls_t                 cls_wr;
  cls_t                 cls_rd;
  logic                 cls_empty;
  logic                 cls_pop;
  logic [OUT_CNT_W-1:0] out_count;
  logic                 out_push;
  res_t                 out_wr;
  res_t                 out_rd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < MAX_POINTS; i++) begin
        points_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_POINT_COUNT) begin
        count_q <= cfg_data_i[PCNT_W-1:0];
      end
      for (int i = 0; i < MAX_POINTS; i++) begin
        if (cfg_index_i == CFG_IDX_W'(i + 1)) begin
          points_q[i] <= cfg_data_i;
        end
      end
    end
  end

  ssi_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .op_i    (op_i),
    .value_i (value_i),
    .count_i (count_q),
    .points_i(points_q),
    .cls_o   (cls_wr)
  );

  ssi_queue #(
    .WIDTH($bits(cls_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cls_wr),
    .full_o (full),
    .pop_i  (cls_pop),
    .empty_o(cls_empty),
    .data_o (cls_rd),
    .count_o()
  );

  ssi_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cls_i      (cls_rd),
    .cls_empty_i(cls_empty),
    .cls_pop_o  (cls_pop),
    .out_count_i(out_count),
    .out_push_o (out_push),
    .out_data_o (out_wr)
  );

  ssi_queue #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_wr),
    .full_o (),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (out_rd),
    .count_o(out_count)
  );

  assign result_o  = out_rd.result;
  assign clamped_o = out_rd.clamped;

endmodule

FILE: sv/ssi_queue.sv
module ssi_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [WIDTH-1:0]               data_i,
  output logic                           full_o,
  input  logic                           pop_i,
  output logic                           empty_o,
  output logic [WIDTH-1:0]               data_o,
  output logic [$clog2(DEPTH + 1)-1:0]   count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             wr_en;
  logic             rd_en;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: sv/ssi_front.sv
module ssi_front #(
  parameter int unsigned MAX_POINTS = 7
) (
  input  logic                          op_i,
  input  logic [ssi_pkg::KEY_W-1:0]     value_i,
  input  logic [ssi_pkg::PCNT_W-1:0]    count_i,
  input  ssi_pkg::point_t               points_i [MAX_POINTS],
  output ssi_pkg::cls_t                 cls_o
);

  import ssi_pkg::*;

  logic [KEY_W-1:0] key   [MAX_POINTS];
  logic [KEY_W-1:0] outv  [MAX_POINTS];
  logic [MAX_POINTS-1:0] lt;
  logic [MAX_POINTS-1:0] ge;
  logic [KEY_W-1:0] l_in, l_out, r_in, r_out;
  logic             have_right;
  logic [KEY_W:0]   diff;

  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      key[i]  = op_i ? KEY_W'(points_i[i][POINT_W-1:KEY_W]) : points_i[i][KEY_W-1:0];
      outv[i] = op_i ? points_i[i][KEY_W-1:0] : KEY_W'(points_i[i][POINT_W-1:KEY_W]);
      lt[i]   = (count_i > PCNT_W'(i)) && (key[i] < value_i);
      ge[i]   = (count_i > PCNT_W'(i)) && (key[i] >= value_i);
    end
  end

  always_comb begin
    l_in  = '0;
    l_out = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (lt[i]) begin
        l_in  = key[i];
        l_out = outv[i];
      end
    end
    r_in  = '0;
    r_out = '0;
    for (int i = MAX_POINTS - 1; i >= 0; i--) begin
      if (ge[i]) begin
        r_in  = key[i];
        r_out = outv[i];
      end
    end
    have_right = |ge;
  end

  always_comb begin
    diff          = {1'b0, r_out} - {1'b0, l_out};
    cls_o.num     = value_i - l_in;
    cls_o.den     = r_in - l_in;
    cls_o.neg     = diff[KEY_W];
    cls_o.mag     = diff[KEY_W] ? KEY_W'(-diff) : diff[KEY_W-1:0];
    cls_o.clamped = !have_right;
    if (!have_right) begin
      cls_o.direct = 1'b1;
      cls_o.base   = l_out;
    end else if (r_in <= l_in) begin
      cls_o.direct = 1'b1;
      cls_o.base   = r_out;
    end else begin
      cls_o.direct = 1'b0;
      cls_o.base   = l_out;
    end
  end

endmodule

FILE: sv/ssi_back.sv
module ssi_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ssi_pkg::cls_t                  cls_i,
  input  logic                           cls_empty_i,
  output logic                           cls_pop_o,
  input  logic [ssi_pkg::OUT_CNT_W-1:0]  out_count_i,
  output logic                           out_push_o,
  output ssi_pkg::res_t                  out_data_o
);

  import ssi_pkg::*;

  typedef struct packed {
    logic             direct;
    logic             clamped;
    logic [KEY_W-1:0] base;
    logic             neg;
    logic [KEY_W-1:0] den;
    logic [KEY_W-1:0] rem;
    logic [KEY_W-1:0] sh;
  } div_stage_t;

  logic                  s0_valid_q;
  cls_t                  s0_cls_q;
  logic [PROD_W-1:0]     s0_prod_q;
  logic [DIV_STEPS-1:0]  dv_valid_q;
  div_stage_t            dv_q [DIV_STEPS];
  div_stage_t            dv_d [DIV_STEPS];
  logic [OUT_CNT_W-1:0]  inflight_q, inflight_d;
  logic [OUT_CNT_W:0]    occupancy;
  div_stage_t            last;

  function automatic div_stage_t div_step(div_stage_t s);
    logic [KEY_W:0] t;
    logic           take;
    div_stage_t     r;
    t      = {s.rem, s.sh[KEY_W-1]};
    take   = (t >= {1'b0, s.den});
    r      = s;
    r.rem  = take ? KEY_W'(t - {1'b0, s.den}) : t[KEY_W-1:0];
    r.sh   = {s.sh[KEY_W-2:0], take};
    return r;
  endfunction

  assign occupancy = {1'b0, inflight_q} + {1'b0, out_count_i};
  assign cls_pop_o = !cls_empty_i && (occupancy < (OUT_CNT_W + 1)'(OUT_DEPTH));

  always_comb begin
    div_stage_t first;
    first.direct  = s0_cls_q.direct;
    first.clamped = s0_cls_q.clamped;
    first.base    = s0_cls_q.base;
    first.neg     = s0_cls_q.neg;
    first.den     = s0_cls_q.den;
    first.rem     = s0_prod_q[PROD_W-1:KEY_W];
    first.sh      = s0_prod_q[KEY_W-1:0];
    dv_d[0]       = div_step(first);
    for (int j = 1; j < DIV_STEPS; j++) begin
      dv_d[j] = div_step(dv_q[j-1]);
    end
  end

  assign last       = dv_q[DIV_STEPS-1];
  assign out_push_o = dv_valid_q[DIV_STEPS-1];

  always_comb begin
    out_data_o.clamped = last.clamped;
    if (last.direct) begin
      out_data_o.result = last.base;
    end else if (last.neg) begin
      out_data_o.result = last.base - last.sh;
    end else begin
      out_data_o.result = last.base + last.sh;
    end
  end

  always_comb begin
    inflight_d = inflight_q;
    if (cls_pop_o && !out_push_o) begin
      inflight_d = inflight_q + OUT_CNT_W'(1);
    end else if (out_push_o && !cls_pop_o) begin
      inflight_d = inflight_q - OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      dv_valid_q <= '0;
      inflight_q <= '0;
    end else begin
      s0_valid_q <= cls_pop_o;
      dv_valid_q <= {dv_valid_q[DIV_STEPS-2:0], s0_valid_q};
      inflight_q <= inflight_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_cls_q  <= cls_i;
    s0_prod_q <= PROD_W'(cls_i.num) * PROD_W'(cls_i.mag);
    for (int j = 0; j < DIV_STEPS; j++) begin
      dv_q[j] <= dv_d[j];
    end
  end

endmodule

FILE: tb/sv/tb_speed_step_interpolator.sv
`timescale 1ns / 100ps

module tb_speed_step_interpolator;

  import ssi_pkg::*;

  localparam int unsigned MAX_PTS  = 7;
  localparam int unsigned PT_IDX_W = $clog2(MAX_PTS);

  localparam logic OP_SPEED_TO_STEP = 1'b0;
  localparam logic OP_STEP_TO_SPEED = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_0 = CFG_IDX_W'(1);

  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned ITEM_TARGET  = 1530;
  localparam int unsigned QUIET_FROM   = 1400;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] sel;
    logic [POINT_W-1:0]   arg;
    bit                   typed;
    logic [KEY_W-1:0]     exp_result;
    logic                 exp_clamped;
  } dir_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 push        = 1'b0;
  logic                 full;
  logic                 op_i        = 1'b0;
  logic [KEY_W-1:0]     value_i     = '0;
  logic                 empty;
  logic                 pop         = 1'b0;
  logic [KEY_W-1:0]     result_o;
  logic                 clamped_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [POINT_W-1:0]   cfg_data_i  = '0;

  // The typed expectation travels with the item, so it is sampled at the transfer.
  logic                 row_typed   = 1'b0;
  res_t                 row_exp     = '0;

  logic [PCNT_W-1:0]    tbl_count   = '0;
  point_t               tbl_pts [MAX_PTS];

  res_t                 conv_due_q [$];
  int unsigned          mismatches  = 0;
  int unsigned          gap_pct     = 20;
  int unsigned          stall_pct   = 20;
  int unsigned          hold_cycles = 0;
  bit                   quiet       = 1'b0;

  dir_row_t             dir_rows [33];

  speed_step_interpolator #(
    .MAX_POINTS (MAX_PTS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .value_i     (value_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .clamped_o   (clamped_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    foreach (tbl_pts[i]) tbl_pts[i] = '0;
  end

  function automatic res_t interpolate(input logic op, input logic [KEY_W-1:0] v);
    int unsigned n;
    int unsigned i;
    int unsigned key;
    int unsigned outv;
    int unsigned l_in;
    int unsigned l_out;
    int unsigned r_in;
    int unsigned r_out;
    bit          have_r;
    longint      q;
    res_t        r;
    n      = (tbl_count > PCNT_W'(MAX_PTS)) ? MAX_PTS : 32'(tbl_count);
    l_in   = 0;
    l_out  = 0;
    r_in   = 0;
    r_out  = 0;
    have_r = 1'b0;
    for (i = 0; i < n; i++) begin
      key  = op ? 32'(tbl_pts[PT_IDX_W'(i)][22:16]) : 32'(tbl_pts[PT_IDX_W'(i)][15:0]);
      outv = op ? 32'(tbl_pts[PT_IDX_W'(i)][15:0]) : 32'(tbl_pts[PT_IDX_W'(i)][22:16]);
      if (key < 32'(v)) begin
        l_in  = key;
        l_out = outv;
      end else if (!have_r) begin
        have_r = 1'b1;
        r_in   = key;
        r_out  = outv;
      end
    end
    r.clamped = !have_r;
    if (!have_r) begin
      r.result = l_out[KEY_W-1:0];
    end else if (r_in <= l_in) begin
      r.result = r_out[KEY_W-1:0];
    end else begin
      q = ((longint'(v) - longint'(l_in)) * (longint'(r_out) - longint'(l_out)))
          / (longint'(r_in) - longint'(l_in));
      r.result = KEY_W'(longint'(l_out) + q);
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (pop && !empty) begin
      if (conv_due_q.size() == 0) begin
        $display("%0t: unexpected result, actual result %0d clamped %0b",
                 $time, result_o, clamped_o);
        mismatches++;
      end else begin
        want = conv_due_q.pop_front();
        if (result_o !== want.result) begin
          $display("%0t: result mismatch, expected %0d, actual %0d",
                   $time, want.result, result_o);
          mismatches++;
        end
        if (clamped_o !== want.clamped) begin
          $display("%0t: clamped mismatch, expected %0b, actual %0b",
                   $time, want.clamped, clamped_o);
          mismatches++;
        end
      end
    end
    if (push && !full) begin
      conv_due_q.push_back(row_typed ? row_exp : interpolate(op_i, value_i));
    end
  end

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_cycles != 0) begin
        pop <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(input logic op, input logic [KEY_W-1:0] v, input bit typed,
                           input res_t want);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    push      <= 1'b1;
    op_i      <= op;
    value_i   <= v;
    row_typed <= typed;
    row_exp   <= want;
    do @(posedge clk_i); while (full);
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (conv_due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [POINT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_POINT_COUNT) begin
      tbl_count = data[PCNT_W-1:0];
    end else begin
      tbl_pts[idx - REG_POINT_0] = data;
    end
  endtask

  task automatic load_random_table(input int unsigned phase);
    int unsigned      mode;
    int unsigned      cnt;
    int unsigned      i;
    int unsigned      s;
    int unsigned      t;
    logic [POINT_W-1:0] data;
    mode = $urandom_range(0, 4);
    if (phase == 1) begin
      cnt = 0;
    end else if (phase == 2) begin
      cnt = MAX_PTS;
    end else begin
      cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 7);
    end
    s = 0;
    t = (mode == 1) ? 127 : 0;
    for (i = 0; i < MAX_PTS; i++) begin
      if (mode == 0) begin
        data = POINT_W'($urandom);
      end else begin
        if ($urandom_range(0, 9) != 0) s = s + $urandom_range(0, (65535 - s) / 3);
        if (i + 1 == cnt && $urandom_range(0, 3) == 0) s = 65535;
        if (mode == 1) t = t - $urandom_range(0, t / 3);
        else t = t + $urandom_range(0, (127 - t) / 3);
        data = {t[STEP_W-1:0], s[KEY_W-1:0]};
      end
      cfg_write(REG_POINT_0 + CFG_IDX_W'(i), data);
    end
    cfg_write(REG_POINT_COUNT, POINT_W'(cnt));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned      sent;
    int unsigned      phase;
    int unsigned      n_items;
    int unsigned      k;
    int unsigned      sel;
    int unsigned      key;
    logic             op;
    logic [KEY_W-1:0] v;
    point_t           p;

    dir_rows = '{
      '{ROW_ITEM, CFG_IDX_W'(OP_SPEED_TO_STEP), 23'd0,     1'b1, 16'd0,     1'b1},
      '{ROW_ITEM, CFG_IDX_W'(OP_STEP_TO_SPEED), 23'd65535, 1'b1, 16'd0,     1'b1},
      '{ROW_CFG,  REG_POINT_0,                  {7'd10, 16'd100},    1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  REG_POINT_0 + 3'd1,           {7'd40, 16'd1000},   1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  REG_POINT_0 + 3'd2,           {7'd50, 16'd1000},   1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  REG_POINT_0 + 3'd3,           {7'd127, 16'd65535}, 1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  REG_POINT_COUNT,              23'd4,     1'b0, 16'd0,     1'b0},
      '{ROW_ITEM, CFG_IDX_W'(OP_SPEED_TO_STEP), 23'd0,     1'b1, 16'd0,     1'b0},
      '{ROW_ITEM, CFG_IDX_W'(OP_SPEED_TO_STEP), 23'd100,   1'b1, 16'd10,    1'b0},
      '{ROW_ITEM, CFG_IDX_W'(OP_SPEED_TO_STEP), 23'd50,    1'b1, 16'd5,     1'b0},
      '{ROW_ITEM, CFG_IDX_W'(OP_SPEED_TO_STEP), 23'd1000,  1'b1, 16'd40,    1'b0},
      '{ROW_ITEM, CFG_IDX_W'(OP_SPEED_TO_STEP), 23'd1001,  1'b0, 16'd0,     1'b0},
      '{ROW_ITEM, CFG_IDX_W'(OP_SPEED_TO_STEP), 23'd65535, 1'b1, 16'd127,   1'b0},
      '{ROW_ITEM, CFG_IDX_W'(OP_STEP_TO_SPEED), 23'd0,     1'b1, 16'd0,     1'b0},
      '{ROW_ITEM, CFG_IDX_W'(OP_STEP_TO_SPEED), 23'd127,   1'b1, 16'd65535, 1'b0},
      '{ROW_ITEM, CFG_IDX_W'(OP_STEP_TO_SPEED), 23'd128,   1'b1, 16'd65535, 1'b1},
      '{ROW_ITEM, CFG_IDX_W'(OP_STEP_TO_SPEED), 23'd65535, 1'b1, 16'd65535, 1'b1},
      '{ROW_ITEM, CFG_IDX_W'(OP_STEP_TO_SPEED), 23'd45,    1'b0, 16'd0,     1'b0},
      '{ROW_CFG,  REG_POINT_0,                  {7'd99, 16'd0},      1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  REG_POINT_0 + 3'd1,           {7'd20, 16'd500},    1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  REG_POINT_0 + 3'd2,           {7'd5, 16'd200},     1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  REG_POINT_0 + 3'd3,           23'h7FFFFF,          1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  REG_POINT_0 + 3'd4,           23'd0,               1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  REG_POINT_0 + 3'd5,           {7'd64, 16'd3000},   1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  REG_POINT_0 + 3'd6,           {7'd1, 16'd40000},   1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  REG_POINT_COUNT,              23'd7,     1'b0, 16'd0,     1'b0},
      '{ROW_ITEM, CFG_IDX_W'(OP_SPEED_TO_STEP), 23'd0,     1'b1, 16'd99,    1'b0},
      '{ROW_ITEM, CFG_IDX_W'(OP_SPEED_TO_STEP), 23'd300,   1'b0, 16'd0,     1'b0},
      '{ROW_ITEM, CFG_IDX_W'(OP_SPEED_TO_STEP), 23'd65535, 1'b0, 16'd0,     1'b0},
      '{ROW_ITEM, CFG_IDX_W'(OP_STEP_TO_SPEED), 23'd0,     1'b0, 16'd0,     1'b0},
      '{ROW_ITEM, CFG_IDX_W'(OP_STEP_TO_SPEED), 23'd60,    1'b0, 16'd0,     1'b0},
      '{ROW_ITEM, CFG_IDX_W'(OP_STEP_TO_SPEED), 23'd127,   1'b0, 16'd0,     1'b0},
      '{ROW_ITEM, CFG_IDX_W'(OP_STEP_TO_SPEED), 23'd3,     1'b0, 16'd0,     1'b0}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        settle();
        cfg_write(dir_rows[r].sel, dir_rows[r].arg);
      end else begin
        cfg_valid_i <= 1'b0;
        send_item(dir_rows[r].sel[0], dir_rows[r].arg[KEY_W-1:0], dir_rows[r].typed,
                  '{result: dir_rows[r].exp_result, clamped: dir_rows[r].exp_clamped});
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < ITEM_TARGET) begin
      settle();
      load_random_table(phase);
      if (phase == 0) begin
        // Hold the result side back long enough for the block to fill and refuse items.
        gap_pct     = 0;
        stall_pct   = 0;
        hold_cycles = 300;
        n_items     = 120;
      end else begin
        gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        n_items   = $urandom_range(40, 120);
      end
      for (k = 0; k < n_items; k++) begin
        op  = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 9);
        p   = tbl_pts[PT_IDX_W'($urandom_range(0, MAX_PTS - 1))];
        key = op ? 32'(p[22:16]) : 32'(p[15:0]);
        if (sel < 4) begin
          v = KEY_W'(key + $urandom_range(0, 2) - 1);
        end else if (sel == 4) begin
          v = $urandom_range(0, 1) ? '1 : '0;
        end else if (op == OP_STEP_TO_SPEED && sel != 5) begin
          v = KEY_W'($urandom_range(0, 127));
        end else begin
          v = KEY_W'($urandom);
        end
        send_item(op, v, 1'b0, '0);
      end
      sent += n_items;
      if (sent >= QUIET_FROM) quiet = 1'b1;
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
